>>> design/cas_pkg.sv
// Shared constants for the cave smoothing pass.
package cas_pkg;

  localparam int COL_W = 10;
  localparam int ROW_W = 12;
  localparam int GW_W  = 11;
  localparam int GH_W  = 13;
  localparam int APB_AW = 3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = 11'd64;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = 13'd64;

  // Window bits that survive a shift: column 0 and 1 of each row.
  localparam logic [8:0] WIN_KEEP = 9'h0DB;

  localparam int SUM_MIN   = 5;
  localparam int NEIGH_MIN = 4;

endpackage

>>> design/cas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/cave_automaton_smoothing_pass.sv
// Top level: one 3x3 cave smoothing pass over a raster stream of cells.
// Throughput is one cell per clock; a new request is taken every cycle the output can drain.
// An accepted request is captured in the stage register, and its line buffer read
// is launched at the accepting edge; the rule is applied as the stage moves to the result register.
// The result for a cell leaves W+1 requests after that cell enters; W+1 drain requests flush a frame.
// Synchronous reset clears counters, window, pipeline valids and sets both size registers to 64.
module cave_automaton_smoothing_pass
  import cas_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // s_axis_tdata: [0] cell_value, [7:1] zero
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  // s_axis_tuser: [0] drain
  input  logic              s_axis_tuser,
  // m_axis_tdata: [0] new_value, [10:1] column, [22:11] row_index, [23] zero
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic          v;
    logic          emit;
    logic          last;
    logic [CW-1:0] idx;
    logic [CW-1:0] col;
    logic [ORW-1:0] row;
  } stage_t;

  // Configuration registers.
  logic [GW_W-1:0] grid_width;
  logic [GH_W-1:0] grid_height;
  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? 32'(grid_height) : 32'(grid_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_GRID_HEIGHT) begin
        grid_height <= pwdata[GH_W-1:0];
      end else begin
        grid_width <= pwdata[GW_W-1:0];
      end
    end
  end

  always_comb begin
    if (grid_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
  end

  // Position counters and the stage register.
  logic [CW-1:0]  in_col, in_col_next;
  logic [IRW-1:0] in_row, in_row_next;
  logic [CW-1:0]  out_col, out_col_next;
  logic [ORW-1:0] out_row, out_row_next;
  logic           s1_valid, s1_valid_next;
  stage_t         s1, s1_next;
  logic           s1_fire;
  logic           accept;
  logic           after_frame, ignore, emit, last;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign after_frame = 32'(in_row) >= 32'(eff_h);
  assign ignore      = s_axis_tuser && !after_frame;
  assign emit        = (in_row >= IRW'(1) && in_col != '0) || in_row >= IRW'(2);
  assign last        = (32'(out_row) + 1 >= 32'(eff_h)) && (32'(out_col) + 1 >= 32'(eff_w));

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (accept && !ignore) begin
      if (32'(in_col) + 1 >= 32'(eff_w)) begin
        in_col_next = '0;
        if (32'(in_row) < MAX_HEIGHT + 1) begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_col_next = in_col + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (32'(out_col) + 1 >= 32'(eff_w)) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_next.v    = after_frame ? 1'b0 : s_axis_tdata[0];
    s1_next.emit = emit;
    s1_next.last = last;
    s1_next.idx  = in_col;
    s1_next.col  = out_col;
    s1_next.row  = out_row;
  end

  assign s1_fire       = s1_valid && (!s1.emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_comb begin
    if (accept) begin
      s1_valid_next = !ignore;
    end else if (s1_fire) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      s1 <= s1_next;
    end
  end

  // Line buffers: bit 1 holds the upper row, bit 0 the middle row.
  logic       rd_en;
  logic [1:0] ram_q, lines, wr_data;
  logic       byp;
  logic [1:0] byp_data;

  assign rd_en   = accept && !ignore;
  assign lines   = byp ? byp_data : ram_q;
  assign wr_data = {lines[0], s1.v};

  cas_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1.idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_col),
    .rd_data (ram_q)
  );

  // A read of the entry being written in the same cycle returns stale data, so forward it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= s1_fire && (in_col == s1.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  // Window update and the smoothing rule.
  logic [8:0] window, window_next;
  logic [2:0] cv, rv;
  logic [3:0] count, sum;
  logic       result;

  assign window_next = ((window >> 1) & WIN_KEEP) | {3'b000, lines[0], 2'b00, lines[1], 2'b00}
                       | {s1.v, 8'h00};

  always_comb begin
    cv[0] = s1.col != '0;
    cv[1] = 32'(s1.col) < 32'(eff_w);
    cv[2] = 32'(s1.col) + 1 < 32'(eff_w);
    rv[0] = s1.row != '0;
    rv[1] = 32'(s1.row) < 32'(eff_h);
    rv[2] = 32'(s1.row) + 1 < 32'(eff_h);
    count = '0;
    sum   = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rv[r] && cv[c]) begin
          sum = sum + 4'(window_next[r*3+c]);
          if (!(r == 1 && c == 1)) begin
            count = count + 4'd1;
          end
        end
      end
    end
    result = (count >= 4'(NEIGH_MIN)) && (sum >= 4'(SUM_MIN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_fire) begin
      window <= s1.last ? 9'd0 : window_next;
    end
  end

  // Result register.
  logic m_valid_next;

  always_comb begin
    if (s1_fire && s1.emit) begin
      m_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_next = 1'b0;
    end else begin
      m_valid_next = m_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.emit) begin
      m_axis_tdata <= {1'b0, ROW_W'(s1.row), COL_W'(s1.col), result};
      m_axis_tlast <= s1.last;
    end
  end

endmodule

>>> tb/tb_cave_automaton_smoothing_pass.sv
// Self-checking testbench for the cave smoothing pass, with scoreboard and stream/APB drivers.
module tb_cave_automaton_smoothing_pass;
  timeunit 1ns;
  timeprecision 1ps;
  import cas_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;

  typedef struct packed {
    logic              new_value;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row_index;
    logic              frame_last;
  } smoothed_cell_t;

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Tracks the grid position, the two line buffers and the window, and keeps
  // the smoothed cells that the block still owes.
  class cave_pass_tracker;
    logic [GW_W-1:0] width_reg;
    logic [GH_W-1:0] height_reg;
    bit              upper_row[MAX_W];
    bit              middle_row[MAX_W];
    logic [8:0]      window;
    int              in_col, in_row, out_col, out_row;
    smoothed_cell_t  smoothed_q[$];
    int              errors, checked, solid;

    function new();
      width_reg  = GRID_WIDTH_RESET;
      height_reg = GRID_HEIGHT_RESET;
      window     = '0;
      in_col     = 0;
      in_row     = 0;
      out_col    = 0;
      out_row    = 0;
      errors     = 0;
      checked    = 0;
      solid      = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_GRID_WIDTH) width_reg = value[GW_W-1:0];
      else height_reg = value[GH_W-1:0];
    endfunction

    function int pending();
      return smoothed_q.size();
    endfunction

    // 3x3 rule on the window around (out_col, out_row); off-grid positions do not count.
    function bit smooth_rule(int w, int h);
      int count, sum, x, y;
      count = 0;
      sum   = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          x = out_col + c - 1;
          y = out_row + r - 1;
          if (x < 0 || y < 0 || x >= w || y >= h) continue;
          sum += window[r*3+c];
          if (!(r == 1 && c == 1)) count++;
        end
      end
      return (count >= NEIGH_MIN) && (sum >= SUM_MIN);
    endfunction

    function void take_cell(bit cell_bit, bit drain);
      int             w, h, idx;
      bit             v, up, mid, emit;
      logic [8:0]     nw;
      smoothed_cell_t e;
      w = clamp_size(width_reg, MAX_W);
      h = clamp_size(height_reg, MAX_H);
      v = cell_bit;
      // A drain request inside the frame is dropped; data past the frame counts as drain.
      if (drain && in_row < h) return;
      if (in_row >= h) v = 1'b0;
      idx = (in_col < MAX_W) ? in_col : MAX_W - 1;
      up  = upper_row[idx];
      mid = middle_row[idx];
      nw    = (window >> 1) & WIN_KEEP;
      nw[2] = up;
      nw[5] = mid;
      nw[8] = v;
      window = nw;
      upper_row[idx]  = mid;
      middle_row[idx] = v;
      emit = (in_row >= 1 && in_col >= 1) || in_row >= 2;
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row < MAX_H + 1) in_row++;
      end else begin
        in_col++;
      end
      if (!emit) return;
      e.new_value  = smooth_rule(w, h);
      e.column     = out_col[COL_W-1:0];
      e.row_index  = out_row[ROW_W-1:0];
      e.frame_last = (out_row >= h - 1) && (out_col >= w - 1);
      smoothed_q = {smoothed_q, e};
      if (e.frame_last) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        window  = '0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        if (errors < 20)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_cell(logic [23:0] data, logic last);
      smoothed_cell_t e;
      if (smoothed_q.size() == 0) begin
        if (errors < 20)
          $display("%0t: unexpected result, expected none, actual data %0h last %0b",
                   $time, data, last);
        errors++;
        return;
      end
      e = smoothed_q.pop_front();
      checked++;
      if (e.new_value) solid++;
      field_ok("new_value", e.new_value, data[0]);
      field_ok("column", e.column, data[10:1]);
      field_ok("row_index", e.row_index, data[22:11]);
      field_ok("frame_last", e.frame_last, last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  cave_pass_tracker sb = new();
  bit idle_on = 1'b0;
  int frames_done = 0;
  int stall_left = 0;

  cave_automaton_smoothing_pass #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.take_cell(s_axis_tdata[0], s_axis_tuser);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_cell(m_axis_tdata, m_axis_tlast);
  end

  task automatic send_req(bit cell_bit, bit drain);
    int g;
    g = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, cell_bit};
    s_axis_tuser  <= drain;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic stop_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_compare(logic idx, logic [31:0] exp_v);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_access(1'b0, idx, '0, rd);
    mask = (idx == REG_GRID_WIDTH) ? 32'h7FF : 32'h1FFF;
    if ((rd & mask) !== (exp_v & mask)) begin
      $display("%0t: register %0d read back, expected %0h, actual %0h",
               $time, idx, exp_v & mask, rd & mask);
      sb.errors++;
    end
  endtask

  task automatic reg_write(logic idx, int value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    sb.write_reg(idx, value);
    reg_compare(idx, value);
  endtask

  // Sizes change only at a frame boundary, after the last result and the pipeline tail.
  task automatic set_size(int w_raw, int h_raw);
    wait_drained();
    repeat (8) @(posedge clk);
    reg_write(REG_GRID_WIDTH, w_raw);
    reg_write(REG_GRID_HEIGHT, h_raw);
  endtask

  task automatic send_frame(int w, int h, int pct, bit noisy, int pause_at);
    for (int i = 0; i < w * h; i++) begin
      if (i == pause_at) begin
        stop_requests();
        wait_drained();
      end
      if (noisy && $urandom_range(0, 99) < 5) send_req($urandom_range(0, 1), 1'b1);
      send_req($urandom_range(0, 99) < pct, 1'b0);
    end
    // W+1 flush requests; in a noisy frame some of them carry data instead of the drain flag.
    for (int i = 0; i <= w; i++) send_req($urandom_range(0, 1), noisy ? $urandom_range(0, 1) : 1'b1);
    if (noisy && $urandom_range(0, 1)) send_req($urandom_range(0, 1), 1'b1);
    stop_requests();
    frames_done++;
  endtask

  initial begin
    int         rand_items, frame_no, w_raw, h_raw, w_eff, h_eff, pct;
    int         dens[5];
    bit [8:0]   pat;
    dens = '{0, 25, 50, 70, 100};
    pat  = 9'b110111011;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_compare(REG_GRID_WIDTH, GRID_WIDTH_RESET);
    reg_compare(REG_GRID_HEIGHT, GRID_HEIGHT_RESET);

    // 3x3 frame with a dropped drain inside it, a data request used as drain,
    // and a drain after the frame end that must be ignored.
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      send_req(pat[i], 1'b0);
      if (i == 3) send_req(1'b1, 1'b1);
    end
    send_req(1'b1, 1'b0);
    repeat (3) send_req(1'b0, 1'b1);
    send_req(1'b1, 1'b1);
    stop_requests();
    frames_done++;

    // Width register at zero is taken as one cell.
    set_size(0, 2);
    send_req(1'b1, 1'b0);
    send_req(1'b1, 1'b0);
    repeat (2) send_req(1'b0, 1'b1);
    stop_requests();
    frames_done++;

    // Height register at zero is taken as one row.
    set_size(2, 0);
    send_req(1'b1, 1'b0);
    send_req(1'b1, 1'b0);
    repeat (3) send_req(1'b0, 1'b1);
    stop_requests();
    frames_done++;

    rand_items = 0;
    frame_no   = 0;
    while (rand_items < 1750) begin
      case (frame_no)
        4:  begin w_raw = 10;   h_raw = 10;   end
        default: begin
          w_raw = ($urandom_range(0, 99) < 5) ? 0 :
                  ($urandom_range(0, 99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 40);
          h_raw = ($urandom_range(0, 99) < 5) ? 0 :
                  ($urandom_range(0, 99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        end
      endcase
      set_size(w_raw, h_raw);
      w_eff   = clamp_size(w_raw, MAX_W);
      h_eff   = clamp_size(h_raw, MAX_H);
      idle_on = ($urandom_range(0, 3) != 0);
      pct     = dens[$urandom_range(0, 4)];
      send_frame(w_eff, h_eff, pct, $urandom_range(0, 1),
                 (frame_no == 4) ? (w_eff * h_eff) / 2 : -1);
      rand_items += w_eff * h_eff + w_eff + 1;
      frame_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d frames of 1x1 up to 40x40 cells, %0d cells checked, %0d solid.",
             frames_done, sb.checked, sb.solid);
    $display("Mixed in dropped drains, data used as flush, zero sizes and stalls on both sides.");
    if (sb.errors == 0) begin
      $display("tb_cave_automaton_smoothing_pass OK");
    end else begin
      $display("tb_cave_automaton_smoothing_pass NOT OK");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("tb_cave_automaton_smoothing_pass NOT OK");
    $finish;
  end

endmodule

>>> files.f
design/cas_pkg.sv
design/cas_ram.sv
design/cave_automaton_smoothing_pass.sv
tb/tb_cave_automaton_smoothing_pass.sv
